[design/tcc_pkg.sv]
// Shared constants for the triangle circumcircle pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcc_pkg;

    // Default coordinate width in bits (signed fixed point).
    localparam int COORD_WIDTH_DEF = 32;

    // Width of one multiplier slice; wide products are built from these.
    localparam int MUL_CHUNK = 32;

endpackage

`default_nettype wire

[design/tcc_mul.sv]
// Pipelined signed multiplier built from MUL_CHUNK x MUL_CHUNK partial products.
// Depends on tcc_pkg. Registered stages advance only with en; carries a sideband word.
`default_nettype none

module tcc_mul
    import tcc_pkg::*;
#(
    parameter int AW  = 32,
    parameter int BW  = 32,
    parameter int SBW = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 vld_i,
    input  logic [AW-1:0]        a,
    input  logic [BW-1:0]        b,
    input  logic [SBW-1:0]       sb_i,
    output logic                 vld_o,
    output logic [AW+BW-1:0]     p,
    output logic [SBW-1:0]       sb_o
);

    localparam int NA   = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB   = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int AXW  = NA * MUL_CHUNK;
    localparam int BXW  = NB * MUL_CHUNK;
    localparam int PW   = AW + BW;
    localparam int SUMW = AXW + BXW;
    localparam int PPW  = 2 * MUL_CHUNK;

    logic [AW-1:0]   a_mag;
    logic [BW-1:0]   b_mag;
    logic [AXW-1:0]  ma_reg;
    logic [BXW-1:0]  mb_reg;
    logic [PPW-1:0]  pp_reg [NA*NB];
    logic [SUMW-1:0] sum_next;
    logic [PW-1:0]   sum_reg;
    logic [PW-1:0]   p_reg;
    logic            neg1_reg, neg2_reg, neg3_reg;
    logic [SBW-1:0]  sb1_reg, sb2_reg, sb3_reg, sb4_reg;
    logic [3:0]      vld_reg;

    // Magnitudes of the two's complement operands.
    assign a_mag = a[AW-1] ? (~a + AW'(1)) : a;
    assign b_mag = b[BW-1] ? (~b + BW'(1)) : b;

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], vld_i};
        end
    end

    // Stage 1: magnitudes and product sign.
    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= AXW'(a_mag);
            mb_reg   <= BXW'(b_mag);
            neg1_reg <= a[AW-1] ^ b[BW-1];
            sb1_reg  <= sb_i;
        end
    end

    // Stage 2: one partial product per slice pair.
    for (genvar i = 0; i < NA; i++) begin : g_pa
        for (genvar j = 0; j < NB; j++) begin : g_pb
            always_ff @(posedge aclk) begin
                if (en) begin
                    pp_reg[i*NB+j] <= ma_reg[i*MUL_CHUNK +: MUL_CHUNK]
                                    * mb_reg[j*MUL_CHUNK +: MUL_CHUNK];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg2_reg <= neg1_reg;
            sb2_reg  <= sb1_reg;
        end
    end

    // Stage 3: align and add the partial products.
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                sum_next = sum_next + (SUMW'(pp_reg[i*NB+j]) << (MUL_CHUNK * (i + j)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg  <= sum_next[PW-1:0];
            neg3_reg <= neg2_reg;
            sb3_reg  <= sb2_reg;
        end
    end

    // Stage 4: restore the sign.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg   <= neg3_reg ? (~sum_reg + PW'(1)) : sum_reg;
            sb4_reg <= sb3_reg;
        end
    end

    assign vld_o = vld_reg[3];
    assign p     = p_reg;
    assign sb_o  = sb4_reg;

endmodule

`default_nettype wire

[design/tcc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on tcc_pkg. Stages advance only with en.
`default_nettype none

module tcc_div
    import tcc_pkg::*;
#(
    parameter int NUMW = 101,
    parameter int DENW = 69,
    parameter int QW   = 32,
    parameter int SBW  = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             vld_i,
    input  logic [NUMW-1:0]  num,
    input  logic [DENW-1:0]  den,
    input  logic [SBW-1:0]   sb_i,
    output logic             vld_o,
    output logic [QW-1:0]    q,
    output logic [SBW-1:0]   sb_o
);

    localparam int CW = (NUMW > DENW + QW) ? NUMW : DENW + QW;

    logic [NUMW-1:0] rem_reg [QW-1];
    logic [DENW-1:0] den_reg [QW-1];
    logic [QW-1:0]   q_reg   [QW];
    logic [SBW-1:0]  sb_reg  [QW];
    logic [QW-1:0]   vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QW-2:0], vld_i};
        end
    end

    // Each stage tries the shifted divisor against the partial remainder.
    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int BITP = QW - 1 - k;

        logic [NUMW-1:0] rem_in;
        logic [DENW-1:0] den_in;
        logic [QW-1:0]   q_in;
        logic [SBW-1:0]  sb_in;
        logic [CW-1:0]   trial;
        logic            take;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
            assign sb_in  = sb_i;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign sb_in  = sb_reg[k-1];
        end

        assign trial = CW'(den_in) << BITP;
        assign take  = CW'(rem_in) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]  <= q_in | (take ? (QW'(1) << BITP) : '0);
                sb_reg[k] <= sb_in;
            end
        end

        // The last stage needs no remainder or divisor.
        if (k < QW - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? NUMW'(CW'(rem_in) - trial) : rem_in;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign vld_o = vld_reg[QW-1];
    assign q     = q_reg[QW-1];
    assign sb_o  = sb_reg[QW-1];

endmodule

`default_nettype wire

[design/tcc_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on tcc_pkg. Stages advance only with en; returns root and remainder.
`default_nettype none

module tcc_sqrt
    import tcc_pkg::*;
#(
    parameter int SW  = 66,
    parameter int RW  = 33,
    parameter int SBW = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            vld_i,
    input  logic [SW-1:0]   s,
    input  logic [SBW-1:0]  sb_i,
    output logic            vld_o,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   rem,
    output logic [SBW-1:0]  sb_o
);

    localparam int CW = SW + 1;

    logic [SW-1:0]  rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    logic [SBW-1:0] sb_reg   [RW];
    logic [RW-1:0]  vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[RW-2:0], vld_i};
        end
    end

    // Stage k decides root bit RW-1-k: (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i).
    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam int BITP = RW - 1 - k;

        logic [SW-1:0]  rem_in;
        logic [RW-1:0]  root_in;
        logic [SBW-1:0] sb_in;
        logic [CW-1:0]  trial;
        logic           take;

        if (k == 0) begin : g_first
            assign rem_in  = s;
            assign root_in = '0;
            assign sb_in   = sb_i;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sb_in   = sb_reg[k-1];
        end

        assign trial = (CW'(root_in) << (BITP + 1)) | (CW'(1) << (2 * BITP));
        assign take  = CW'(rem_in) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? SW'(CW'(rem_in) - trial) : rem_in;
                root_reg[k] <= root_in | (take ? (RW'(1) << BITP) : '0);
                sb_reg[k]   <= sb_in;
            end
        end
    end

    assign vld_o = vld_reg[RW-1];
    assign root  = root_reg[RW-1];
    assign rem   = rem_reg[RW-1];
    assign sb_o  = sb_reg[RW-1];

endmodule

`default_nettype wire

[design/triangle_circumcircle.sv]
// Circumcircle of a triangle: centre by the determinant formula, radius by square root.
// Depends on tcc_pkg, tcc_mul, tcc_div and tcc_sqrt.
// The divider and square root resolve one bit per stage.
// Throughput: one triangle per cycle, stalls only on output backpressure.
// Reset: synchronous, active-low aresetn clears all valid bits and the output skid stage.
`default_nettype none

module triangle_circumcircle
    import tcc_pkg::*;
#(
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_DW  = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((3 * COORD_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // ax, ay, bx, by_coord, cx, cy, from the lowest bit up
    input  logic [IN_DW-1:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // center_x, center_y, radius, degenerate, overflow, from the lowest bit up
    output logic [OUT_DW-1:0] m_axis_tdata
);

    localparam int W    = COORD_WIDTH;
    localparam int DW1  = W + 1;            // coordinate difference
    localparam int SQW  = 2 * W;            // coordinate square
    localparam int CRW  = W + DW1;          // coordinate times difference
    localparam int A2W  = 2 * W + 1;        // squared norm
    localparam int DW   = 2 * W + 4;        // shared divisor
    localparam int MBW  = A2W + DW1;        // norm times difference
    localparam int NW   = 3 * W + 4;        // numerators
    localparam int NUMW = NW + 1;           // 2|N| + |D|
    localparam int DENW = DW + 1;           // 2|D|
    localparam int LW   = NUMW + 1;         // range check
    localparam int SW   = 2 * W + 2;        // squared distance
    localparam int RW   = W + 1;            // root bits
    localparam int SBA  = 2 * W + 6 * DW1;
    localparam int SBB  = 2 * W + DW;
    localparam int SBD  = 2 * W + 5;
    localparam int SBC  = 2 * W + 2;
    localparam int FW   = 3 * W + 1;

    localparam logic [W-1:0]  SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [RW:0]   RMAX = (RW+1)'({(W-1){1'b1}});

    logic adv;

    // Stage 0: input register.
    logic           v0_reg;
    logic [W-1:0]   p0_reg [6];

    // Stage 1: points and differences.
    logic           v1_reg;
    logic [W-1:0]   p1_reg [6];
    logic [DW1-1:0] diff1_reg [6];

    // Products of the first multiplier bank.
    logic           va_o;
    logic [SQW-1:0] sq_p [6];
    logic [CRW-1:0] cr_p [3];
    logic [SBA-1:0] sba_i, sba_o;

    // Stage 2: norms and divisor.
    logic           v2_reg;
    logic [A2W-1:0] norm2_reg [3];
    logic [DW-1:0]  d2_reg;
    logic [DW1-1:0] diff2_reg [6];
    logic [W-1:0]   ax2_reg, ay2_reg;

    // Products of the second multiplier bank.
    logic           vb_o;
    logic [MBW-1:0] mb_p [6];
    logic [SBB-1:0] sbb_o;

    // Stage 3: numerators.
    logic           v3_reg;
    logic [NW-1:0]  nx3_reg, ny3_reg;
    logic [DW-1:0]  d3_reg;
    logic [W-1:0]   ax3_reg, ay3_reg;

    // Stage 4: magnitudes for the rounded division.
    logic           v4_reg;
    logic [NUMW-1:0] numx4_reg, numy4_reg;
    logic [DENW-1:0] den4_reg;
    logic           degen4_reg, negx4_reg, negy4_reg;
    logic [W-1:0]   ax4_reg, ay4_reg;
    logic [NW-1:0]  anx, any_m;
    logic [DW-1:0]  ad;

    // Stage 5: range check of the quotients.
    logic           v5_reg;
    logic [NUMW-1:0] numx5_reg, numy5_reg;
    logic [DENW-1:0] den5_reg;
    logic           degen5_reg, negx5_reg, negy5_reg, ovx5_reg, ovy5_reg;
    logic [W-1:0]   ax5_reg, ay5_reg;
    logic [LW-1:0]  limx, limy;

    // Divider outputs.
    logic           vd_o;
    logic [W-1:0]   qx, qy;
    logic [SBD-1:0] sbd_o;
    logic           d_negx, d_negy, d_ovx, d_ovy;

    // Stage 6: saturated centre.
    logic           v6_reg;
    logic [W-1:0]   ux6_reg, uy6_reg, ax6_reg, ay6_reg;
    logic           ov6_reg, degen6_reg;

    // Stage 7: distance to the first point.
    logic           v7_reg;
    logic [W-1:0]   ux7_reg, uy7_reg;
    logic [DW1-1:0] dx7_reg, dy7_reg;
    logic           ov7_reg, degen7_reg;

    // Distance squares.
    logic           vc_o;
    logic [2*DW1-1:0] dsq_p [2];
    logic [SBC-1:0] sbc_o;

    // Stage 8: squared radius.
    logic           v8_reg;
    logic [SW-1:0]  s8_reg;
    logic [SBC-1:0] sb8_reg;

    // Square root outputs and final assembly.
    logic           vs_o;
    logic [RW-1:0]  root;
    logic [SW-1:0]  rem;
    logic [SBC-1:0] sbs_o;
    logic [RW:0]    rr;
    logic           rsat, f_ov, f_degen;
    logic [W-2:0]   radius;
    logic           fin_valid;
    logic [OUT_DW-1:0] fin_data;

    // Output register and skid stage.
    logic              m_valid_reg, skid_valid_reg;
    logic [OUT_DW-1:0] m_data_reg, skid_data_reg;

    // The pipeline moves whenever the skid stage is free.
    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;

    // Valid bits of the local stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= va_o;
            v3_reg <= vb_o;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= vd_o;
            v7_reg <= v6_reg;
            v8_reg <= vc_o;
        end
    end

    // Stage 0 and 1: capture the beat, then form the six differences.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 6; k++) begin
                p0_reg[k] <= s_axis_tdata[k*W +: W];
                p1_reg[k] <= p0_reg[k];
            end
            diff1_reg[0] <= DW1'($signed(p0_reg[3])) - DW1'($signed(p0_reg[5]));
            diff1_reg[1] <= DW1'($signed(p0_reg[5])) - DW1'($signed(p0_reg[1]));
            diff1_reg[2] <= DW1'($signed(p0_reg[1])) - DW1'($signed(p0_reg[3]));
            diff1_reg[3] <= DW1'($signed(p0_reg[4])) - DW1'($signed(p0_reg[2]));
            diff1_reg[4] <= DW1'($signed(p0_reg[0])) - DW1'($signed(p0_reg[4]));
            diff1_reg[5] <= DW1'($signed(p0_reg[2])) - DW1'($signed(p0_reg[0]));
        end
    end

    assign sba_i = {p1_reg[0], p1_reg[1], diff1_reg[5], diff1_reg[4], diff1_reg[3],
                    diff1_reg[2], diff1_reg[1], diff1_reg[0]};

    // First bank: squares of the coordinates and the divisor terms.
    for (genvar k = 0; k < 6; k++) begin : g_sq
        if (k == 0) begin : g_carry
            tcc_mul #(.AW(W), .BW(W), .SBW(SBA)) u_mul (
                .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(v1_reg),
                .a(p1_reg[k]), .b(p1_reg[k]), .sb_i(sba_i),
                .vld_o(va_o), .p(sq_p[k]), .sb_o(sba_o)
            );
        end else begin : g_plain
            tcc_mul #(.AW(W), .BW(W), .SBW(1)) u_mul (
                .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(v1_reg),
                .a(p1_reg[k]), .b(p1_reg[k]), .sb_i(1'b0),
                .vld_o(), .p(sq_p[k]), .sb_o()
            );
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_cr
        tcc_mul #(.AW(W), .BW(DW1), .SBW(1)) u_mul (
            .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(v1_reg),
            .a(p1_reg[2*k]), .b(diff1_reg[k]), .sb_i(1'b0),
            .vld_o(), .p(cr_p[k]), .sb_o()
        );
    end

    // Stage 2: squared norms and D = 2*(sum of cross terms).
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                norm2_reg[k] <= A2W'($signed(sq_p[2*k])) + A2W'($signed(sq_p[2*k+1]));
            end
            d2_reg <= (DW'($signed(cr_p[0])) + DW'($signed(cr_p[1]))
                       + DW'($signed(cr_p[2]))) << 1;
            for (int k = 0; k < 6; k++) begin
                diff2_reg[k] <= sba_o[k*DW1 +: DW1];
            end
            ay2_reg <= sba_o[6*DW1 +: W];
            ax2_reg <= sba_o[6*DW1+W +: W];
        end
    end

    // Second bank: norms times differences for both numerators.
    for (genvar k = 0; k < 6; k++) begin : g_nm
        if (k == 0) begin : g_carry
            tcc_mul #(.AW(A2W), .BW(DW1), .SBW(SBB)) u_mul (
                .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(v2_reg),
                .a(norm2_reg[k%3]), .b(diff2_reg[k]), .sb_i({ax2_reg, ay2_reg, d2_reg}),
                .vld_o(vb_o), .p(mb_p[k]), .sb_o(sbb_o)
            );
        end else begin : g_plain
            tcc_mul #(.AW(A2W), .BW(DW1), .SBW(1)) u_mul (
                .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(v2_reg),
                .a(norm2_reg[k%3]), .b(diff2_reg[k]), .sb_i(1'b0),
                .vld_o(), .p(mb_p[k]), .sb_o()
            );
        end
    end

    // Stage 3: numerators of both centre coordinates.
    always_ff @(posedge aclk) begin
        if (adv) begin
            nx3_reg <= NW'($signed(mb_p[0])) + NW'($signed(mb_p[1])) + NW'($signed(mb_p[2]));
            ny3_reg <= NW'($signed(mb_p[3])) + NW'($signed(mb_p[4])) + NW'($signed(mb_p[5]));
            d3_reg  <= sbb_o[0 +: DW];
            ay3_reg <= sbb_o[DW +: W];
            ax3_reg <= sbb_o[DW+W +: W];
        end
    end

    // Stage 4: round to nearest as floor((2|N| + |D|) / (2|D|)).
    assign anx   = nx3_reg[NW-1] ? (~nx3_reg + NW'(1)) : nx3_reg;
    assign any_m = ny3_reg[NW-1] ? (~ny3_reg + NW'(1)) : ny3_reg;
    assign ad    = d3_reg[DW-1] ? (~d3_reg + DW'(1)) : d3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            numx4_reg  <= (NUMW'(anx) << 1) + NUMW'(ad);
            numy4_reg  <= (NUMW'(any_m) << 1) + NUMW'(ad);
            den4_reg   <= DENW'(ad) << 1;
            degen4_reg <= (d3_reg == '0);
            negx4_reg  <= nx3_reg[NW-1] ^ d3_reg[DW-1];
            negy4_reg  <= ny3_reg[NW-1] ^ d3_reg[DW-1];
            ax4_reg    <= ax3_reg;
            ay4_reg    <= ay3_reg;
        end
    end

    // Stage 5: a quotient fits when it stays below 2^(W-1), or 2^(W-1)+1 if negative.
    assign limx = (LW'(den4_reg) << (W - 1)) + (negx4_reg ? LW'(den4_reg) : LW'(0));
    assign limy = (LW'(den4_reg) << (W - 1)) + (negy4_reg ? LW'(den4_reg) : LW'(0));

    always_ff @(posedge aclk) begin
        if (adv) begin
            numx5_reg  <= numx4_reg;
            numy5_reg  <= numy4_reg;
            den5_reg   <= den4_reg;
            degen5_reg <= degen4_reg;
            negx5_reg  <= negx4_reg;
            negy5_reg  <= negy4_reg;
            ovx5_reg   <= LW'(numx4_reg) >= limx;
            ovy5_reg   <= LW'(numy4_reg) >= limy;
            ax5_reg    <= ax4_reg;
            ay5_reg    <= ay4_reg;
        end
    end

    // Dividers for both coordinates; the x unit carries the sideband.
    tcc_div #(.NUMW(NUMW), .DENW(DENW), .QW(W), .SBW(SBD)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(v5_reg),
        .num(numx5_reg), .den(den5_reg),
        .sb_i({ax5_reg, ay5_reg, degen5_reg, negx5_reg, negy5_reg, ovx5_reg, ovy5_reg}),
        .vld_o(vd_o), .q(qx), .sb_o(sbd_o)
    );

    tcc_div #(.NUMW(NUMW), .DENW(DENW), .QW(W), .SBW(1)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(v5_reg),
        .num(numy5_reg), .den(den5_reg), .sb_i(1'b0),
        .vld_o(), .q(qy), .sb_o()
    );

    assign d_ovy  = sbd_o[0];
    assign d_ovx  = sbd_o[1];
    assign d_negy = sbd_o[2];
    assign d_negx = sbd_o[3];

    // Stage 6: apply the sign, saturate out-of-range coordinates.
    always_ff @(posedge aclk) begin
        if (adv) begin
            ux6_reg    <= d_ovx ? (d_negx ? SMIN : SMAX) : (d_negx ? (~qx + W'(1)) : qx);
            uy6_reg    <= d_ovy ? (d_negy ? SMIN : SMAX) : (d_negy ? (~qy + W'(1)) : qy);
            ov6_reg    <= d_ovx | d_ovy;
            degen6_reg <= sbd_o[4];
            ay6_reg    <= sbd_o[5 +: W];
            ax6_reg    <= sbd_o[5+W +: W];
        end
    end

    // Stage 7: offset of the rounded centre from the first point.
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx7_reg    <= DW1'($signed(ux6_reg)) - DW1'($signed(ax6_reg));
            dy7_reg    <= DW1'($signed(uy6_reg)) - DW1'($signed(ay6_reg));
            ux7_reg    <= ux6_reg;
            uy7_reg    <= uy6_reg;
            ov7_reg    <= ov6_reg;
            degen7_reg <= degen6_reg;
        end
    end

    tcc_mul #(.AW(DW1), .BW(DW1), .SBW(SBC)) u_mul_dx (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(v7_reg),
        .a(dx7_reg), .b(dx7_reg), .sb_i({ux7_reg, uy7_reg, ov7_reg, degen7_reg}),
        .vld_o(vc_o), .p(dsq_p[0]), .sb_o(sbc_o)
    );

    tcc_mul #(.AW(DW1), .BW(DW1), .SBW(1)) u_mul_dy (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(v7_reg),
        .a(dy7_reg), .b(dy7_reg), .sb_i(1'b0),
        .vld_o(), .p(dsq_p[1]), .sb_o()
    );

    // Stage 8: squared radius, both squares are non-negative.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_reg  <= SW'(dsq_p[0]) + SW'(dsq_p[1]);
            sb8_reg <= sbc_o;
        end
    end

    tcc_sqrt #(.SW(SW), .RW(RW), .SBW(SBC)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(v8_reg),
        .s(s8_reg), .sb_i(sb8_reg),
        .vld_o(vs_o), .root(root), .rem(rem), .sb_o(sbs_o)
    );

    // Round the root to nearest, saturate, and pack the result beat.
    assign rr      = (RW+1)'(root) + (RW+1)'(rem > SW'(root));
    assign rsat    = rr > RMAX;
    assign f_degen = sbs_o[0];
    assign f_ov    = sbs_o[1] | rsat;
    assign radius  = (sbs_o[1] | rsat) ? RMAX[W-2:0] : rr[W-2:0];

    // Collinear points carry only the degenerate flag.
    assign fin_valid = vs_o;
    assign fin_data  = f_degen ? OUT_DW'({1'b0, 1'b1, {(FW-2){1'b0}}})
                     : OUT_DW'({f_ov, 1'b0, radius, sbs_o[2 +: W], sbs_o[2+W +: W]});

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_axis_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= fin_valid;
            end
        end else if (fin_valid && adv) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_axis_tready || !m_valid_reg) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : fin_data;
        end else if (adv) begin
            skid_data_reg <= fin_data;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

[design/tcc_checker.sv]
// Port-level checks on the circumcircle block, attached by the bind below.
// Depends on tcc_pkg and on the port list of triangle_circumcircle.
`default_nettype none

module tcc_checker
    import tcc_pkg::*;
#(
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_DW  = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((3 * COORD_WIDTH + 1 + 7) / 8) * 8
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [IN_DW-1:0]  s_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_DW-1:0] m_axis_tdata
);

    localparam int W       = COORD_WIDTH;
    localparam int DEG_BIT = 3 * W - 1;
    localparam int OVF_BIT = 3 * W;

    // A held result beat keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Collinear points give a zero centre and radius and no overflow.
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[DEG_BIT] |->
            m_axis_tdata[DEG_BIT-1:0] == '0 && !m_axis_tdata[OVF_BIT])
        else $error("degenerate beat carries nonzero fields");

    // Any saturation reports the largest radius.
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[OVF_BIT] |->
            m_axis_tdata[2*W +: W-1] == {(W-1){1'b1}})
        else $error("overflow beat without saturated radius");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind triangle_circumcircle tcc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tcc_checker (.*);

`default_nettype wire
